// ===== hw/rtl/note_name_to_frequency_parser_unit_macros.svh =====
// Assertion macros shared by the note parser checker.
`ifndef NOTE_NAME_TO_FREQUENCY_PARSER_UNIT_MACROS_SVH
`define NOTE_NAME_TO_FREQUENCY_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NNFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nnfp check failed");

// Next-cycle implication, disabled during reset.
`define NNFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nnfp check failed");

`endif

// ===== hw/rtl/nnfp_pkg.sv =====
// Types, constants and the frequency table for the note name parser.
package nnfp_pkg;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_LETTER,
    PH_ACC,
    PH_DIGITS,
    PH_DONE,
    PH_REST
  } phase_t;

  typedef enum logic [2:0] {
    ST_NOTE,
    ST_REST,
    ST_BAD_LETTER,
    ST_OCT_MISSING,
    ST_OCT_BAD,
    ST_RANGE
  } status_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_SHARP,
    ACC_FLAT
  } acc_t;

  localparam logic [2:0] REST_MISMATCH = 3'd7;
  localparam logic [6:0] OCT_MAX       = 7'd99;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] rest_prog;
    logic [3:0] note_base;
    acc_t       acc;
    logic       oct_neg;
    logic [6:0] oct_mag;
    status_t    err;
    logic       space_pending;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:         PH_LEAD,
    rest_prog:     3'd0,
    note_base:     4'd0,
    acc:           ACC_NONE,
    oct_neg:       1'b0,
    oct_mag:       7'd0,
    err:           ST_NOTE,
    space_pending: 1'b0
  };

  // 2^(k/12) scaled by 10^12, rounded
  localparam logic [63:0] SEMITONE_RATIO [12] = '{
    64'd1000000000000, 64'd1059463094359, 64'd1122462048309, 64'd1189207115003,
    64'd1259921049895, 64'd1334839854170, 64'd1414213562373, 64'd1498307076877,
    64'd1587401051968, 64'd1681792830507, 64'd1781797436281, 64'd1887748625363
  };

  typedef logic [21:0] freq_rom_t [128];

  // Frequency in Q8 for every MIDI number, rounded half up; built at elaboration.
  function automatic freq_rom_t build_freq_rom();
    freq_rom_t   rom;
    logic [63:0] num;
    logic [63:0] t;
    int unsigned d;
    int unsigned q;
    int unsigned r;
    int unsigned s;
    for (int m = 0; m < 128; m++) begin
      d   = m + 51;
      q   = d / 12;
      r   = d % 12;
      num = 64'd112640 * SEMITONE_RATIO[r];
      if (q >= 10) begin
        num = num << (q - 10);
        t   = (num + 64'd500000000000) / 64'd1000000000000;
      end else begin
        s = 10 - q;
        t = (num + (64'd1000000000000 << (s - 1))) / 64'd1000000000000;
        t = t >> s;
      end
      rom[m] = t[21:0];
    end
    return rom;
  endfunction

  localparam freq_rom_t FREQ_ROM = build_freq_rom();

endpackage

// ===== hw/rtl/note_name_to_frequency_parser_unit.sv =====
// Note name parser: one request byte per cycle while char_stall is low, one result per message.
// The last byte's state is registered in the pending stage, then loaded into the output register behind result_valid.
// Throughput: one byte per cycle while char_stall is low, set by the byte-wide parse step before the state registers.
// A stalled result holds the pending stage; a second finished message then raises char_stall.
// Reset (rst, synchronous, active high) clears the parser state, the pending stage and
// result_valid; payload registers are left as they are.
module note_name_to_frequency_parser_unit #(
  parameter int MESSAGE_BUFFER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  input  logic        char_valid,
  output logic        char_stall,
  output logic [2:0]  status,
  output logic [6:0]  midi_note,
  output logic [21:0] freq_q8,
  output logic        result_valid,
  input  logic        result_stall
);

  // kept-byte counter must hold MESSAGE_BUFFER_BYTES-1
  localparam int KW = $clog2(MESSAGE_BUFFER_BYTES);
  localparam logic [KW-1:0] KEEP_LIMIT = KW'(MESSAGE_BUFFER_BYTES - 1);

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  nnfp_pkg::parse_state_t st, st_next;
  nnfp_pkg::parse_state_t pend;
  logic [KW-1:0]          kept, kept_next;
  logic                   pend_valid;
  logic                   char_accept;
  logic                   pend_move;

  // The pending stage drains into the output register whenever that register
  // is empty or being taken; only a full, blocked pending stage stalls input.
  assign pend_move   = pend_valid && (!result_valid || !result_stall);
  assign char_stall  = pend_valid && result_valid && result_stall;
  assign char_accept = char_valid && !char_stall;

  // ---------------------------------------------------------------------------
  // Byte classification
  // ---------------------------------------------------------------------------
  logic [7:0] lc;
  logic       is_ws;
  logic       is_digit;
  logic [3:0] digit;
  logic [9:0] mag_acc;

  assign lc       = (char_code >= "A" && char_code <= "Z") ? char_code + 8'd32 : char_code;
  assign is_ws    = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
  assign is_digit = (char_code >= "0") && (char_code <= "9");
  assign digit    = 4'(char_code - "0");
  // decimal accumulate of the octave magnitude, saturated below
  assign mag_acc  = 10'(st.oct_mag) * 10'd10 + 10'(digit);

  // ---------------------------------------------------------------------------
  // Parse step: next state for one accepted byte
  // ---------------------------------------------------------------------------
  always_comb begin
    st_next   = st;
    kept_next = kept;
    if (kept < KEEP_LIMIT) begin
      if (char_code == 8'd0) begin
        // a zero byte ends the text: freeze the counter at the limit
        kept_next = KEEP_LIMIT;
      end else begin
        kept_next = kept + KW'(1);
        unique case (st.phase)
          nnfp_pkg::PH_LEAD: begin
            if (is_ws) begin
              // drop leading whitespace
            end else if (lc == "r") begin
              st_next.rest_prog = 3'd1;
              st_next.phase     = nnfp_pkg::PH_REST;
            end else begin
              st_next.phase = nnfp_pkg::PH_LETTER;
              unique case (lc)
                "c":     st_next.note_base = 4'd0;
                "d":     st_next.note_base = 4'd2;
                "e":     st_next.note_base = 4'd4;
                "f":     st_next.note_base = 4'd5;
                "g":     st_next.note_base = 4'd7;
                "a":     st_next.note_base = 4'd9;
                "b":     st_next.note_base = 4'd11;
                default: begin
                  st_next.err   = nnfp_pkg::ST_BAD_LETTER;
                  st_next.phase = nnfp_pkg::PH_DONE;
                end
              endcase
            end
          end
          nnfp_pkg::PH_LETTER, nnfp_pkg::PH_ACC: begin
            priority if (is_ws) begin
              st_next.space_pending = 1'b1;
            end else if (st.space_pending) begin
              // whitespace inside the note: octave cannot start here
              st_next.err   = nnfp_pkg::ST_OCT_BAD;
              st_next.phase = nnfp_pkg::PH_DONE;
            end else if (st.phase == nnfp_pkg::PH_LETTER && char_code == "#") begin
              st_next.acc   = nnfp_pkg::ACC_SHARP;
              st_next.phase = nnfp_pkg::PH_ACC;
            end else if (st.phase == nnfp_pkg::PH_LETTER && lc == "b") begin
              st_next.acc   = nnfp_pkg::ACC_FLAT;
              st_next.phase = nnfp_pkg::PH_ACC;
            end else if (char_code == "-") begin
              st_next.oct_neg = 1'b1;
              st_next.phase   = nnfp_pkg::PH_DIGITS;
            end else if (is_digit) begin
              st_next.oct_mag = 7'(digit);
              st_next.phase   = nnfp_pkg::PH_DIGITS;
            end else begin
              st_next.err   = nnfp_pkg::ST_OCT_BAD;
              st_next.phase = nnfp_pkg::PH_DONE;
            end
          end
          nnfp_pkg::PH_DIGITS: begin
            if (is_digit) begin
              st_next.oct_mag = (mag_acc > 10'(nnfp_pkg::OCT_MAX)) ? nnfp_pkg::OCT_MAX
                                                                   : mag_acc[6:0];
            end else begin
              // first non-digit closes the octave; ignore the rest
              st_next.phase = nnfp_pkg::PH_DONE;
            end
          end
          nnfp_pkg::PH_REST: begin
            priority if (is_ws) begin
              st_next.space_pending = 1'b1;
            end else if (!st.space_pending && st.rest_prog == 3'd1 && lc == "e") begin
              st_next.rest_prog = 3'd2;
            end else if (!st.space_pending && st.rest_prog == 3'd2 && lc == "s") begin
              st_next.rest_prog = 3'd3;
            end else if (!st.space_pending && st.rest_prog == 3'd3 && lc == "t") begin
              st_next.rest_prog = 3'd4;
            end else begin
              st_next.rest_prog = nnfp_pkg::REST_MISMATCH;
            end
          end
          default: begin
            // done: hold
          end
        endcase
      end
    end
  end

  // Advance the parser; the last byte hands its state to the pending stage
  // and returns the parser to its reset state for the next message.
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= nnfp_pkg::PARSE_RESET;
      kept       <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (char_accept) begin
        if (last_char) begin
          st   <= nnfp_pkg::PARSE_RESET;
          kept <= '0;
        end else begin
          st   <= st_next;
          kept <= kept_next;
        end
      end
      pend_valid <= (pend_valid && !pend_move) || (char_accept && last_char);
    end
  end

  always_ff @(posedge clk) begin
    if (char_accept && last_char) begin
      pend <= st_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: status, MIDI number and table lookup
  // ---------------------------------------------------------------------------
  logic signed [8:0]  oct_plus1;
  logic signed [11:0] acc_adj;
  logic signed [11:0] midi_val;
  nnfp_pkg::status_t  status_next;
  logic [6:0]         midi_next;
  logic [21:0]        freq_next;

  assign oct_plus1 = (pend.oct_neg ? -$signed({2'b00, pend.oct_mag})
                                   :  $signed({2'b00, pend.oct_mag})) + 9'sd1;

  always_comb begin
    unique case (pend.acc)
      nnfp_pkg::ACC_SHARP: acc_adj = 12'sd1;
      nnfp_pkg::ACC_FLAT:  acc_adj = -12'sd1;
      default:             acc_adj = 12'sd0;
    endcase
  end

  assign midi_val = 12'(oct_plus1) * 12'sd12 + $signed({8'b0, pend.note_base}) + acc_adj;

  always_comb begin
    status_next = nnfp_pkg::ST_NOTE;
    midi_next   = 7'd0;
    freq_next   = 22'd0;
    priority if (pend.err != nnfp_pkg::ST_NOTE) begin
      status_next = pend.err;
    end else if (pend.phase == nnfp_pkg::PH_LEAD) begin
      status_next = nnfp_pkg::ST_BAD_LETTER;
    end else if (pend.phase == nnfp_pkg::PH_REST) begin
      status_next = (pend.rest_prog == 3'd1 || pend.rest_prog == 3'd4)
                    ? nnfp_pkg::ST_REST : nnfp_pkg::ST_BAD_LETTER;
    end else if (pend.phase == nnfp_pkg::PH_LETTER || pend.phase == nnfp_pkg::PH_ACC) begin
      status_next = nnfp_pkg::ST_OCT_MISSING;
    end else if (midi_val < 12'sd0 || midi_val > 12'sd127) begin
      status_next = nnfp_pkg::ST_RANGE;
    end else begin
      midi_next = midi_val[6:0];
      freq_next = nnfp_pkg::FREQ_ROM[midi_val[6:0]];
    end
  end

  // Output register: load from the pending stage, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pend_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      status    <= status_next;
      midi_note <= midi_next;
      freq_q8   <= freq_next;
    end
  end

endmodule

// ===== hw/rtl/nnfp_checker.sv =====
// Port-level checker for the note name parser, bound to every instance of the parser module.
`include "note_name_to_frequency_parser_unit_macros.svh"

module nnfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        char_stall,
  input logic [2:0]  status,
  input logic [6:0]  midi_note,
  input logic [21:0] freq_q8,
  input logic        result_valid,
  input logic        result_stall
);

  logic        is_note;
  logic [28:0] res_num;
  logic [31:0] res_bits;

  assign is_note  = (status == nnfp_pkg::ST_NOTE);
  assign res_num  = {midi_note, freq_q8};
  assign res_bits = {status, res_num};

  // a held result keeps its payload
  `NNFP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(res_bits))

  // anything but a note carries zero number and frequency
  `NNFP_ASSERT_NOW(a_non_note_zero, result_valid && !is_note, res_num == 29'd0)

  // every valid note has a nonzero frequency
  `NNFP_ASSERT_NOW(a_note_freq, result_valid && is_note, freq_q8 != 22'd0)

  // input stalls only while a result is waiting
  `NNFP_ASSERT_NOW(a_stall_cause, char_stall, result_valid && result_stall)

endmodule

bind note_name_to_frequency_parser_unit nnfp_checker u_nnfp_checker (.*);
